// File: hdl/zero_cross_subharmonic_mixer_core_assert.svh
// assertion macros for the zero crossing subharmonic mixer
`ifndef ZERO_CROSS_SUBHARMONIC_MIXER_CORE_ASSERT_SVH
`define ZERO_CROSS_SUBHARMONIC_MIXER_CORE_ASSERT_SVH

// checked at every clock edge outside reset
`define ZCSM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every clock edge, reset included
`define ZCSM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/zcsm_pkg.sv
// shared types and constants of the zero crossing subharmonic mixer
`default_nettype none

package zcsm_pkg;

  // sample width, Q1.(SAMPLE_BITS-1)
  localparam int SAMPLE_BITS = 24;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DIV_W      = 4;
  localparam int VOL_W      = 8;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIV_A = 2'd0,
    CFG_VOL_A = 2'd1,
    CFG_DIV_B = 2'd2,
    CFG_VOL_B = 2'd3
  } cfg_idx_t;

  // input word
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic                          block_end;
  } in_word_t;

  // result word
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          block_end_out;
  } out_word_t;

endpackage

`default_nettype wire

// File: hdl/zero_cross_subharmonic_mixer_core.sv
// zero crossing subharmonic mixer: octave divider bank and output mix
//
//   channel  | ports                              | moves
//   ---------+------------------------------------+----------------------------
//   in       | in_valid, in_ready, in_data        | one audio sample word
//   out      | out_valid, out_ready, out_data     | one mixed sample word
//   cfg      | cfg_we, cfg_index, cfg_wdata       | one register write, no wait
//
// one word is accepted per cycle unless the output stalls; its result goes to
// w_r (crossing detect and mix sum), then out_data_r (divide by three multiply)
// rst_n is synchronous: it clears the pipeline, the polarity flag, the divider
// phases, the sub levels and restores the register defaults
// a stalled result holds in the output register while one more word enters
`default_nettype none

module zero_cross_subharmonic_mixer_core
  import zcsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // divider bank range and level codes
  localparam int DIV_MIN = 2;
  localparam int DIV_MAX = 8;
  localparam int PH_W    = 4;
  localparam logic [1:0] LVL_SILENT = 2'b00;
  localparam logic [1:0] LVL_POS    = 2'b01;
  localparam logic [1:0] LVL_NEG    = 2'b11;
  localparam logic [VOL_W-1:0] VOL_MAX = VOL_W'(128);
  localparam logic [DIV_W-1:0] DIV_RST = DIV_W'(2);
  localparam logic [VOL_W-1:0] VOL_RST = VOL_W'(64);

  // mix arithmetic widths and constants
  localparam int TERM_W = 10;
  localparam int UW     = SAMPLE_BITS + 2;
  localparam int WW     = SAMPLE_BITS + 3;
  localparam logic [WW-1:0] W_BIAS  = WW'(3) << SAMPLE_BITS;
  localparam logic [WW:0]   W_ONE   = (WW+1)'(1) << WW;
  localparam logic [WW-1:0] RECIP_3 = WW'(W_ONE / 3);
  localparam logic [WW-1:0] Q_HI    = WW'(3) << (SAMPLE_BITS - 1);
  localparam logic [WW-1:0] Q_LO    = WW'(1) << (SAMPLE_BITS - 1);
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  // configuration registers
  logic [DIV_W-1:0] div_a_r, div_b_r;
  logic [VOL_W-1:0] vol_a_r, vol_b_r;

  // crossing state
  logic            flag_r, flag_nxt;
  logic [PH_W-1:0] ph_r   [DIV_MIN:DIV_MAX];
  logic [PH_W-1:0] ph_nxt [DIV_MIN:DIV_MAX];
  logic [1:0]      lvl_r   [DIV_MIN:DIV_MAX];
  logic [1:0]      lvl_nxt [DIV_MIN:DIV_MAX];

  // pipeline
  logic            s1_valid_r;
  logic [WW-1:0]   w_r, w_nxt;
  logic            blk_r;
  logic            out_valid_r;
  out_word_t       out_data_r, out_data_nxt;
  logic            s1_en, s2_en, in_fire;

  // handshake
  assign s2_en    = !out_valid_r || out_ready;
  assign s1_en    = !s1_valid_r || s2_en;
  assign in_ready = s1_en;
  assign in_fire  = in_valid && s1_en;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // zero crossing detect and divider phases
  logic x_pos, x_neg, crossing;
  always_comb begin
    x_pos = !in_data.sample_in[SAMPLE_BITS-1] && (in_data.sample_in != '0);
    x_neg = in_data.sample_in[SAMPLE_BITS-1];
    crossing = (flag_r && x_pos) || (!flag_r && x_neg);
    flag_nxt = flag_r ^ crossing;
    for (int n = DIV_MIN; n <= DIV_MAX; n++) begin
      ph_nxt[n]  = ph_r[n];
      lvl_nxt[n] = lvl_r[n];
      if (crossing) begin
        ph_nxt[n] = (ph_r[n] == PH_W'(2 * n - 1)) ? '0 : ph_r[n] + PH_W'(1);
        if (ph_nxt[n] == '0) begin
          lvl_nxt[n] = LVL_NEG;
        end else if (ph_nxt[n] == PH_W'(n)) begin
          lvl_nxt[n] = LVL_POS;
        end
      end
    end
  end

  // pick the two selected levels, silent when the divisor is out of range
  logic [1:0] lvl_a, lvl_b;
  always_comb begin
    lvl_a = LVL_SILENT;
    lvl_b = LVL_SILENT;
    for (int n = DIV_MIN; n <= DIV_MAX; n++) begin
      if (div_a_r == DIV_W'(n)) lvl_a = lvl_nxt[n];
      if (div_b_r == DIV_W'(n)) lvl_b = lvl_nxt[n];
    end
  end

  // volume weighted levels
  logic [VOL_W-1:0]         va, vb;
  logic signed [TERM_W-1:0] term_a, term_b, s_sum;
  always_comb begin
    va = (vol_a_r > VOL_MAX) ? VOL_MAX : vol_a_r;
    vb = (vol_b_r > VOL_MAX) ? VOL_MAX : vol_b_r;
    case (lvl_a)
      LVL_POS: term_a = $signed({2'b00, va});
      LVL_NEG: term_a = -$signed({2'b00, va});
      default: term_a = '0;
    endcase
    case (lvl_b)
      LVL_POS: term_b = $signed({2'b00, vb});
      LVL_NEG: term_b = -$signed({2'b00, vb});
      default: term_b = '0;
    endcase
    s_sum = term_a + term_b;
  end

  // dividend over 128, plus rounding one, biased nonnegative
  logic signed [UW-1:0] x_ext, s_ext, s_shift, u_sum;
  always_comb begin
    x_ext   = UW'(in_data.sample_in);
    s_ext   = UW'(s_sum);
    s_shift = s_ext <<< (SAMPLE_BITS - 8);
    u_sum   = x_ext + s_shift + UW'(1);
    w_nxt   = {u_sum[UW-1], u_sum} + W_BIAS;
  end

  // divide by three through the reciprocal, one correction step, saturate
  logic [2*WW-1:0] prod;
  logic [WW-1:0]   q0, q1, three_q0, rem;
  always_comb begin
    prod     = {{WW{1'b0}}, w_r} * {{WW{1'b0}}, RECIP_3};
    q0       = prod[2*WW-1:WW];
    three_q0 = {q0[WW-2:0], 1'b0} + q0;
    rem      = w_r - three_q0;
    q1       = (rem >= WW'(3)) ? q0 + WW'(1) : q0;
    if (q1 >= Q_HI) begin
      out_data_nxt.sample_out = $signed(SAMPLE_MAX);
    end else if (q1 < Q_LO) begin
      out_data_nxt.sample_out = $signed(SAMPLE_MIN);
    end else begin
      out_data_nxt.sample_out = $signed(q1[SAMPLE_BITS-1:0]);
    end
    out_data_nxt.block_end_out = blk_r;
  end

  // control state, crossing state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      flag_r      <= 1'b0;
      for (int n = DIV_MIN; n <= DIV_MAX; n++) begin
        ph_r[n]  <= '0;
        lvl_r[n] <= LVL_SILENT;
      end
      div_a_r <= DIV_RST;
      vol_a_r <= VOL_RST;
      div_b_r <= DIV_RST;
      vol_b_r <= VOL_RST;
    end else begin
      if (s1_en) s1_valid_r <= in_valid;
      if (s2_en) out_valid_r <= s1_valid_r;
      if (in_fire) begin
        flag_r <= flag_nxt;
        for (int n = DIV_MIN; n <= DIV_MAX; n++) begin
          ph_r[n]  <= ph_nxt[n];
          lvl_r[n] <= lvl_nxt[n];
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIV_A: div_a_r <= cfg_wdata[DIV_W-1:0];
          CFG_VOL_A: vol_a_r <= cfg_wdata[VOL_W-1:0];
          CFG_DIV_B: div_b_r <= cfg_wdata[DIV_W-1:0];
          CFG_VOL_B: vol_b_r <= cfg_wdata[VOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      w_r   <= w_nxt;
      blk_r <= in_data.block_end;
    end
    if (s2_en && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/zcsm_checker.sv
// port level checker of the zero crossing subharmonic mixer, with its bind
`default_nettype none

`include "zero_cross_subharmonic_mixer_core_assert.svh"

module zcsm_checker
  import zcsm_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  // a stalled result word stays offered
  `ZCSM_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid, "out word dropped while stalled")

  // a stalled result word keeps its value
  `ZCSM_ASSERT(a_out_stable, out_valid && !out_ready |=> $stable(out_data), "out word changed while stalled")

  // input only backs up when the output register is full and stalled
  `ZCSM_ASSERT(a_ready_stall, !in_ready |-> out_valid && !out_ready, "in_ready low without output stall")

  // reset empties the pipeline
  `ZCSM_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_valid, "out_valid high after reset")

endmodule

bind zero_cross_subharmonic_mixer_core zcsm_checker u_zcsm_checker (.*);

`default_nettype wire

// File: test/tb_top.sv
// testbench for the zero crossing subharmonic mixer, checked against a local predictor
module tb_top
  import zcsm_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int COUNT_WRAP    = 1680;
  localparam int PIPE_LATENCY  = 2;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int ERR_PRINT_MAX = 50;
  localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_word_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow copy of the block's state and registers
  logic                  polarity_set;
  logic [10:0]           cross_count;
  logic signed [1:0]     sub_level [2:8];
  logic [DIV_W-1:0]      div_a_reg, div_b_reg;
  logic [VOL_W-1:0]      vol_a_reg, vol_b_reg;

  out_word_t   mix_expected_q [$];
  int          err_count   = 0;
  int          cycle_count = 0;
  bit          idle_en     = 1'b1;
  bit          last_negative = 1'b0;
  int unsigned stall_left  = 0;

  zero_cross_subharmonic_mixer_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d words still expected", $time, mix_expected_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // advance the crossing counter, then set the square levels from its new value
  function automatic void step_dividers();
    int n;
    int unsigned r;
    cross_count = (cross_count == COUNT_WRAP - 1) ? 11'd0 : cross_count + 11'd1;
    for (n = 2; n <= 8; n++) begin
      r = cross_count % (2 * n);
      if (r == 0)
        sub_level[n] = -2'sd1;
      else if (r == n)
        sub_level[n] = 2'sd1;
    end
  endfunction

  // level of a selected divisor, silent outside 2..8
  function automatic longint level_for(logic [DIV_W-1:0] d);
    if (d < 2 || d > 8)
      return 0;
    return longint'(sub_level[d]);
  endfunction

  function automatic longint vol_weight(logic [VOL_W-1:0] v);
    return (v > 128) ? 128 : longint'(v);
  endfunction

  // expected mix for one accepted sample word, updates the shadow state
  function automatic out_word_t mix_sample(in_word_t w);
    longint    x, acc, q, full;
    out_word_t r;
    x    = longint'($signed(w.sample_in));
    full = longint'(1) <<< (SAMPLE_BITS - 1);
    if ((polarity_set && x > 0) || (!polarity_set && x < 0)) begin
      polarity_set = !polarity_set;
      step_dividers();
    end
    acc = x * 128 + (vol_weight(vol_a_reg) * level_for(div_a_reg)
                   + vol_weight(vol_b_reg) * level_for(div_b_reg)) * full;
    // floor division of acc + 192 by 384, offset keeps the dividend positive
    q = (acc + 192 + (longint'(384) <<< SAMPLE_BITS)) / 384 - (longint'(1) <<< SAMPLE_BITS);
    if (q > full - 1)
      q = full - 1;
    if (q < -full)
      q = -full;
    r.sample_out    = q[SAMPLE_BITS-1:0];
    r.block_end_out = w.block_end;
    return r;
  endfunction

  // predictor update and result check
  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      polarity_set = 1'b0;
      cross_count  = '0;
      for (int n = 2; n <= 8; n++)
        sub_level[n] = 2'sd0;
      div_a_reg = 4'd2;
      vol_a_reg = 8'd64;
      div_b_reg = 4'd2;
      vol_b_reg = 8'd64;
      mix_expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_DIV_A: div_a_reg = cfg_wdata[DIV_W-1:0];
          CFG_VOL_A: vol_a_reg = cfg_wdata[VOL_W-1:0];
          CFG_DIV_B: div_b_reg = cfg_wdata[DIV_W-1:0];
          CFG_VOL_B: vol_b_reg = cfg_wdata[VOL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        mix_expected_q.push_back(mix_sample(in_data));
      if (out_valid && out_ready) begin
        if (mix_expected_q.size() == 0) begin
          err_count++;
          if (err_count <= ERR_PRINT_MAX)
            $display("%0t: unexpected word, expected none, got sample_out %0d block_end_out %0b",
                     $time, $signed(out_data.sample_out), out_data.block_end_out);
        end else begin
          want = mix_expected_q.pop_front();
          if (out_data.sample_out !== want.sample_out) begin
            err_count++;
            if (err_count <= ERR_PRINT_MAX)
              $display("%0t: sample_out mismatch, expected %0d, got %0d", $time,
                       $signed(want.sample_out), $signed(out_data.sample_out));
          end
          if (out_data.block_end_out !== want.block_end_out) begin
            err_count++;
            if (err_count <= ERR_PRINT_MAX)
              $display("%0t: block_end_out mismatch, expected %0b, got %0b", $time,
                       want.block_end_out, out_data.block_end_out);
          end
        end
      end
    end
  end

  // receiver back-pressure in random bursts, always ready while idling is off
  always @(posedge clk) begin
    if (!rst_n || !idle_en) begin
      out_ready  <= rst_n;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(7) == 0) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(11);
    end else begin
      out_ready  <= 1'b1;
    end
  end

  // offer one sample word, with an occasional gap first, and wait until taken
  task automatic send_word(input logic signed [SAMPLE_BITS-1:0] smp, input logic blk);
    int unsigned gap;
    in_word_t    w;
    w.sample_in = smp;
    w.block_end = blk;
    if (idle_en && $urandom_range(5) == 0) begin
      gap = $urandom_range(12, 1);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // stop offering words and wait until every result has come out
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mix_expected_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // write all four registers while the block is idle
  task automatic apply_config(input logic [7:0] d_a, input logic [7:0] v_a,
                              input logic [7:0] d_b, input logic [7:0] v_b);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DIV_A;
    cfg_wdata <= d_a;
    @(posedge clk);
    cfg_index <= CFG_VOL_A;
    cfg_wdata <= v_a;
    @(posedge clk);
    cfg_index <= CFG_DIV_B;
    cfg_wdata <= d_b;
    @(posedge clk);
    cfg_index <= CFG_VOL_B;
    cfg_wdata <= v_b;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // mostly legal settings, with extremes and out of range values now and then
  task automatic apply_random_config();
    logic [7:0] cv [4];
    int i;
    for (i = 0; i < 4; i++) begin
      if (i % 2 == 0) begin
        cv[i] = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8, 2));
      end else begin
        case ($urandom_range(7))
          0:       cv[i] = 8'd0;
          1:       cv[i] = 8'd128;
          2:       cv[i] = 8'($urandom_range(255, 129));
          default: cv[i] = 8'($urandom_range(128));
        endcase
      end
    end
    apply_config(cv[0], cv[1], cv[2], cv[3]);
  endtask

  // random sample of a given sign: zero, full scale, small or anything
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(bit negative);
    logic [SAMPLE_BITS-1:0] mag;
    case ($urandom_range(9))
      0:       mag = '0;
      1:       mag = negative ? FULL_NEG : FULL_POS;
      2:       mag = SAMPLE_BITS'($urandom_range(255, 1));
      default: mag = SAMPLE_BITS'($urandom_range((1 << (SAMPLE_BITS - 1)) - 1, 1));
    endcase
    return negative ? -mag : mag;
  endfunction

  // stream of samples where the sign flips with the given chance in percent
  task automatic send_stream(input int count, input int unsigned flip_pct);
    int k;
    for (k = 0; k < count; k++) begin
      if ($urandom_range(99) < flip_pct)
        last_negative = !last_negative;
      send_word(pick_sample(last_negative), $urandom_range(15) == 0);
    end
  endtask

  // reset register values, zero samples, smallest and full scale samples
  task automatic test_defaults();
    send_word('0, 1'b0);
    send_word('0, 1'b1);
    send_word(24'sd1, 1'b0);
    send_word(-24'sd1, 1'b1);
    send_word(FULL_POS, 1'b0);
    send_word(FULL_NEG, 1'b0);
    send_word(FULL_POS, 1'b1);
    send_word(-24'sd1, 1'b0);
    send_word('0, 1'b0);
    send_word(24'sd1, 1'b1);
  endtask

  // both levels at full volume so full scale input saturates or hits the floor
  task automatic test_saturation();
    int i;
    apply_config(8'd2, 8'd128, 8'd2, 8'd128);
    for (i = 0; i < 4; i++) begin
      send_word(FULL_NEG, 1'b0);
      send_word(FULL_POS, i[0]);
    end
    send_word('0, 1'b1);
  endtask

  // silent divisors, clamped volumes and ignored upper register bits
  task automatic test_odd_registers();
    apply_config(8'h00, 8'hFF, 8'hF5, 8'd129);
    send_word(FULL_NEG, 1'b0);
    send_word(FULL_POS, 1'b1);
    send_word(-24'sd3, 1'b0);
    apply_config(8'd1, 8'd0, 8'd9, 8'd200);
    send_word(FULL_POS, 1'b0);
    send_word(FULL_NEG, 1'b1);
    apply_config(8'd8, 8'd0, 8'd15, 8'd128);
    send_word(24'sd5, 1'b0);
  endtask

  // random settings and samples, crossings on most words
  task automatic test_random();
    int phase;
    for (phase = 0; phase < 6; phase++) begin
      if (phase == 0)
        apply_config(8'd8, 8'd128, 8'd3, 8'd0);
      else
        apply_random_config();
      idle_en = (phase != 3);
      send_stream(120, 80);
    end
  endtask

  // long runs of crossings, no idling from here on
  task automatic test_crossing_run();
    idle_en = 1'b0;
    apply_random_config();
    send_stream(220, 95);
    apply_random_config();
    send_stream(220, 95);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_saturation();
    test_odd_registers();
    test_random();
    test_crossing_run();
    settle();
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
